/* sv/windowed_periodic_frame_scheduler_assert.svh */
// Assertion macros for the windowed periodic frame scheduler.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef WINDOWED_PERIODIC_FRAME_SCHEDULER_ASSERT_SVH
`define WINDOWED_PERIODIC_FRAME_SCHEDULER_ASSERT_SVH

// The consequent must hold whenever the antecedent does, outside reset.
`define WPFS_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression must never be true, outside reset.
`define WPFS_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

/* sv/wpfs_pkg.sv */
// Shared types and constants of the windowed periodic frame scheduler.
// No dependencies; used by every module of the block.
package wpfs_pkg;

	// Number of windows and queue depth by default, and the fixed widths of the item fields.
	localparam int WINDOWS_DEF = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int WIN_W       = 3;
	localparam int CMD_W       = 4;
	localparam int EVW         = 4;
	localparam int PERIOD_W    = 16;

	// Input operations.
	localparam logic [1:0] OP_COMPACT  = 2'd0;
	localparam logic [1:0] OP_EXTENDED = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_STORED  = 2'd0;
	localparam logic [1:0] KIND_IGNORED = 2'd1;
	localparam logic [1:0] KIND_FIRED   = 2'd2;

	// One classified item as it waits between the front and back ends.
	typedef struct packed {
		logic                is_tick;
		logic                extended;
		logic [7:0]          b0;
		logic [7:0]          b1;
		logic [7:0]          b2;
		logic [7:0]          b3;
		logic [7:0]          b4;
		logic [PERIOD_W-1:0] stamp;
	} wpfs_item_t;

endpackage

/* sv/wpfs_front.sv */
// Front end: accepts input items, drops repeated ticks and unused codes.
// Depends on wpfs_pkg.
module wpfs_front import wpfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  entry_b0,
	input  logic [7:0]  entry_b1,
	input  logic [7:0]  entry_b2,
	input  logic [7:0]  entry_b3,
	input  logic [7:0]  entry_b4,
	input  logic [31:0] now_stamp,
	input  logic        q_full,
	output logic        q_push,
	output wpfs_item_t  q_item
);

	logic [31:0] prev_stamp_q;
	logic        accept;
	logic        is_load;
	logic        is_tick;

	// An item is taken whenever the queue has room.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_load  = (op == OP_COMPACT) || (op == OP_EXTENDED);
	assign is_tick  = (op == OP_TICK);

	// Only loads and new timestamps reach the back end.
	assign q_push = accept && (is_load || (is_tick && (now_stamp != prev_stamp_q)));

	always_comb begin
		q_item.is_tick  = is_tick;
		q_item.extended = (op == OP_EXTENDED);
		q_item.b0       = entry_b0;
		q_item.b1       = entry_b1;
		q_item.b2       = entry_b2;
		q_item.b3       = entry_b3;
		q_item.b4       = entry_b4;
		q_item.stamp    = now_stamp[PERIOD_W-1:0];
	end

	// Last timestamp seen, for the repeat check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_stamp_q <= '0;
		end else if (accept && is_tick) begin
			prev_stamp_q <= now_stamp;
		end
	end

endmodule

/* sv/wpfs_fifo.sv */
// Short queue of classified items between the front and back ends.
// Depends on wpfs_pkg.
module wpfs_fifo import wpfs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  wpfs_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       avail,
	output wpfs_item_t pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wpfs_item_t      slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign avail    = (count_q != '0);
	assign pop_item = slot_q[rd_ptr_q];

	// Storage is written only at the write pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/wpfs_back.sv */
// Back end: window table, tick scan and fire sequencer, output register.
// Depends on wpfs_pkg.
module wpfs_back import wpfs_pkg::*; #(
	parameter int WINDOWS = WINDOWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_avail,
	input  wpfs_item_t        q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [WIN_W-1:0]  window,
	output logic [CMD_W-1:0]  command,
	output logic [7:0]        tag_kind,
	output logic signed [7:0] dim_level,
	output logic [EVW-1:0]    event_windows,
	output logic              run_last
);

	localparam int IW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(WINDOWS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	// Window table.
	logic [WINDOWS-1:0]  act_q;
	logic [WINDOWS-1:0]  evt_q;
	logic [CMD_W-1:0]    cmd_q    [WINDOWS];
	logic [7:0]          tag_q    [WINDOWS];
	logic [7:0]          dim_q    [WINDOWS];
	logic [PERIOD_W-1:0] period_q [WINDOWS];
	logic [PERIOD_W-1:0] fired_q  [WINDOWS];

	// Sequencer.
	logic [1:0]          state_q;
	logic [IW-1:0]       idx_q;
	logic [WINDOWS-1:0]  mask_q;
	logic [PERIOD_W-1:0] now_q;

	// Output register.
	logic                out_valid_q;
	logic [1:0]          kind_q;
	logic [WIN_W-1:0]    window_q;
	logic [CMD_W-1:0]    command_q;
	logic [7:0]          tag_kind_q;
	logic [7:0]          dim_level_q;
	logic [EVW-1:0]      event_windows_q;
	logic                run_last_q;

	logic                out_free;
	logic                do_load;
	logic [WIN_W-1:0]    ld_win;
	logic                ld_ok;
	logic [IW-1:0]       ld_idx;
	logic [CMD_W-1:0]    ld_cmd;
	logic                ld_evt;
	logic [7:0]          ld_dim;
	logic [PERIOD_W-1:0] ld_period;
	logic [WINDOWS-1:0]  ev_vec;
	logic [EVW-1:0]      ev_now;
	logic [EVW-1:0]      ev_after_load;
	logic [PERIOD_W-1:0] elapsed;
	logic                scan_fire;
	logic [IW-1:0]       pick;
	logic [WINDOWS-1:0]  pick_oh;
	logic [WINDOWS-1:0]  rest_mask;
	logic                do_fire;

	assign out_free = !out_valid_q || !out_stall;

	// Decode a load entry.
	assign ld_win  = q_item.b0[7:5];
	assign ld_ok   = (int'(ld_win) < WINDOWS);
	assign ld_idx  = IW'(ld_win);
	assign ld_cmd  = q_item.b0[CMD_W-1:0];
	assign ld_evt  = q_item.b0[4];
	assign ld_dim  = q_item.extended ? q_item.b1 : {3'b000, q_item.b1[7:4], 1'b0};
	assign ld_period = q_item.extended ? {q_item.b3, q_item.b4}
	                                   : {4'b0000, q_item.b1[3:0], q_item.b2};
	assign do_load = (state_q == ST_IDLE) && q_avail && !q_item.is_tick && out_free;

	// Event-mode count, both now and as it will be once a load lands.
	always_comb begin
		ev_vec        = act_q & evt_q;
		ev_now        = '0;
		ev_after_load = '0;
		for (int i = 0; i < WINDOWS; i++) begin
			ev_now = ev_now + EVW'(ev_vec[i]);
			if (ld_ok && (ld_idx == IW'(i))) begin
				ev_after_load = ev_after_load + EVW'((ld_cmd != '0) && ld_evt);
			end else begin
				ev_after_load = ev_after_load + EVW'(ev_vec[i]);
			end
		end
	end

	// Scan step: one window's elapsed time against its period.
	assign elapsed   = now_q - fired_q[idx_q];
	assign scan_fire = act_q[idx_q] && !evt_q[idx_q] && (elapsed >= period_q[idx_q]);

	// Lowest pending window of the fire mask.
	always_comb begin
		pick    = '0;
		pick_oh = '0;
		for (int i = WINDOWS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = IW'(i);
			end
		end
		pick_oh[pick] = 1'b1;
	end
	assign rest_mask = mask_q & ~pick_oh;
	assign do_fire   = (state_q == ST_EMIT) && (mask_q != '0) && out_free;

	assign q_pop = do_load || ((state_q == ST_IDLE) && q_avail && q_item.is_tick);

	// Sequencer: idle, scan every window, then emit the fired ones in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			mask_q  <= '0;
			now_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_avail && q_item.is_tick) begin
						now_q   <= q_item.stamp;
						idx_q   <= '0;
						mask_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					mask_q[idx_q] <= scan_fire;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (mask_q == '0) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						mask_q <= rest_mask;
						if (rest_mask == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Table updates: loads write an entry, fires record their time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			evt_q <= '0;
			for (int i = 0; i < WINDOWS; i++) begin
				cmd_q[i]    <= '0;
				tag_q[i]    <= '0;
				dim_q[i]    <= '0;
				period_q[i] <= '0;
				fired_q[i]  <= '0;
			end
		end else begin
			if (do_load && ld_ok) begin
				act_q[ld_idx]    <= (ld_cmd != '0);
				evt_q[ld_idx]    <= ld_evt;
				cmd_q[ld_idx]    <= ld_cmd;
				dim_q[ld_idx]    <= ld_dim;
				period_q[ld_idx] <= ld_period;
				if (q_item.extended) begin
					tag_q[ld_idx] <= q_item.b2;
				end
			end
			if (do_fire) begin
				fired_q[pick] <= now_q;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_load || do_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (do_load) begin
			kind_q          <= ld_ok ? KIND_STORED : KIND_IGNORED;
			window_q        <= ld_win;
			command_q       <= '0;
			tag_kind_q      <= '0;
			dim_level_q     <= '0;
			event_windows_q <= ev_after_load;
			run_last_q      <= 1'b1;
		end else if (do_fire) begin
			kind_q          <= KIND_FIRED;
			window_q        <= WIN_W'(pick);
			command_q       <= cmd_q[pick];
			tag_kind_q      <= tag_q[pick];
			dim_level_q     <= dim_q[pick];
			event_windows_q <= ev_now;
			run_last_q      <= (rest_mask == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign window        = window_q;
	assign command       = command_q;
	assign tag_kind      = tag_kind_q;
	assign dim_level     = dim_level_q;
	assign event_windows = event_windows_q;
	assign run_last      = run_last_q;

endmodule

/* sv/windowed_periodic_frame_scheduler.sv */
// Windowed periodic frame scheduler top level: front end, item queue, back end.
// Depends on wpfs_pkg, wpfs_front, wpfs_fifo, wpfs_back and the assertion header.
// Use of the block:
// The input channel (in_valid, in_stall) carries loads and timestamp ticks.
// A load writes one window entry, compact or extended, and gives one result:
// stored, or ignored when the window index is out of range.
// A tick with a new timestamp checks every active timer-mode window and gives
// one fired result per window whose elapsed time has reached its period, in
// ascending window order; run_last marks the last result of an item.
// A repeated timestamp, and the unused operation code, give no result.
// The output channel (out_valid, out_stall) is a single output register.
// A load result passes through the item queue and the output register.
// A load holds the back end only while it is taken; a tick holds it for a pick-up
// step, a scan of every window and one emit step per fired window (one closing
// step when none fires); loads and emits wait while the output is stalled.
// A two-item queue lets the input keep accepting while the back end works.
// Reset clears the whole window table, the last timestamp and the queue.
// While the receiver stalls, the held result stays put and the back end holds its next result;
// the queue fills and then in_stall rises.
module windowed_periodic_frame_scheduler import wpfs_pkg::*; #(
	parameter int WINDOWS = WINDOWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [7:0]        entry_b0,
	input  logic [7:0]        entry_b1,
	input  logic [7:0]        entry_b2,
	input  logic [7:0]        entry_b3,
	input  logic [7:0]        entry_b4,
	input  logic [31:0]       now_stamp,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [WIN_W-1:0]  window,
	output logic [CMD_W-1:0]  command,
	output logic [7:0]        tag_kind,
	output logic signed [7:0] dim_level,
	output logic [EVW-1:0]    event_windows,
	output logic              run_last
);

	`include "windowed_periodic_frame_scheduler_assert.svh"

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_avail;
	wpfs_item_t push_item;
	wpfs_item_t pop_item;

	// Classification of incoming items.
	wpfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.entry_b0  (entry_b0),
		.entry_b1  (entry_b1),
		.entry_b2  (entry_b2),
		.entry_b3  (entry_b3),
		.entry_b4  (entry_b4),
		.now_stamp (now_stamp),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	// Queue between the two ends.
	wpfs_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_item  (pop_item)
	);

	// Table, scan and result generation.
	wpfs_back #(
		.WINDOWS (WINDOWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_avail       (q_avail),
		.q_item        (pop_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.window        (window),
		.command       (command),
		.tag_kind      (tag_kind),
		.dim_level     (dim_level),
		.event_windows (event_windows),
		.run_last      (run_last)
	);

	// Consistency checks.
	`WPFS_NEVER(a_no_push_when_full, q_push && q_full && !q_pop, "queue overflow")
	`WPFS_NEVER(a_no_pop_when_empty, q_pop && !q_avail, "pop from an empty queue")
	`WPFS_IMPLIES(a_load_is_last, out_valid && (kind != KIND_FIRED), run_last, "load not last")
	`WPFS_IMPLIES(a_fire_has_cmd, out_valid && (kind == KIND_FIRED), command != '0, "no command")

endmodule

/* bench/tb_windowed_periodic_frame_scheduler.sv */
// Self-checking testbench for the windowed periodic frame scheduler.
// Drives loads and ticks against a predictor of the window table; depends on
// wpfs_pkg and the windowed_periodic_frame_scheduler top level.
`timescale 1ns / 1ps

module tb_windowed_periodic_frame_scheduler;
	import wpfs_pkg::*;

	localparam int WIN_COUNT    = WINDOWS_DEF;
	localparam int RANDOM_ITEMS = 470;
	localparam int STUCK_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_AT      = 60;
	localparam int DRAIN_CYCLES = 64;
	localparam int REPORT_MAX   = 10;
	// The one operation code that the block leaves unused.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [7:0]  b4;
		logic [31:0] stamp;
	} frame_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [WIN_W-1:0] win;
		logic [CMD_W-1:0] cmd;
		logic [7:0]       tag;
		logic [7:0]       dim;
		logic [EVW-1:0]   evw;
		logic             last;
	} window_report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        op = OP_COMPACT;
	logic [7:0]        entry_b0 = '0;
	logic [7:0]        entry_b1 = '0;
	logic [7:0]        entry_b2 = '0;
	logic [7:0]        entry_b3 = '0;
	logic [7:0]        entry_b4 = '0;
	logic [31:0]       now_stamp = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        kind;
	logic [WIN_W-1:0]  window;
	logic [CMD_W-1:0]  command;
	logic [7:0]        tag_kind;
	logic signed [7:0] dim_level;
	logic [EVW-1:0]    event_windows;
	logic              run_last;

	// Items waiting to be offered, and reports the block still owes.
	frame_item_t    pending[$];
	window_report_t due_reports[$];
	frame_item_t    cur_item;

	// Predicted copy of the window table.
	logic        tbl_on[WIN_COUNT];
	logic        tbl_evt[WIN_COUNT];
	logic [3:0]  tbl_cmd[WIN_COUNT];
	logic [7:0]  tbl_tag[WIN_COUNT];
	logic [7:0]  tbl_dim[WIN_COUNT];
	logic [15:0] tbl_per[WIN_COUNT];
	logic [31:0] tbl_fired_at[WIN_COUNT];
	logic [31:0] tbl_last_stamp;

	int accepted_items;
	int loads_seen;
	int ticks_seen;
	int reports_seen;
	int fires_seen;
	int fail_count;
	int stuck_cycles;
	int hold_left;
	bit hold_done;
	window_report_t got;
	window_report_t want;

	windowed_periodic_frame_scheduler #(
		.WINDOWS(WIN_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.entry_b0(entry_b0),
		.entry_b1(entry_b1),
		.entry_b2(entry_b2),
		.entry_b3(entry_b3),
		.entry_b4(entry_b4),
		.now_stamp(now_stamp),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.window(window),
		.command(command),
		.tag_kind(tag_kind),
		.dim_level(dim_level),
		.event_windows(event_windows),
		.run_last(run_last)
	);

	// Free-running 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one accepted item to the table copy and queues the reports it causes.
	task automatic predict_window_reports(input frame_item_t it);
		logic [2:0]     w;
		logic [15:0]    gap;
		int             evw;
		window_report_t rep;
		window_report_t batch[$];
		if (it.op == OP_COMPACT || it.op == OP_EXTENDED) begin
			loads_seen++;
			w = it.b0[7:5];
			rep = '0;
			rep.win = w;
			rep.kind = KIND_IGNORED;
			if (int'(w) < WIN_COUNT) begin
				tbl_cmd[w] = it.b0[3:0];
				tbl_evt[w] = it.b0[4];
				tbl_on[w] = (it.b0[3:0] != 4'd0);
				if (it.op == OP_COMPACT) begin
					// Compact dimming is the nibble doubled; the tag is kept.
					tbl_dim[w] = {3'b000, it.b1[7:4], 1'b0};
					tbl_per[w] = {4'h0, it.b1[3:0], it.b2};
				end else begin
					tbl_dim[w] = it.b1;
					tbl_tag[w] = it.b2;
					tbl_per[w] = {it.b3, it.b4};
				end
				rep.kind = KIND_STORED;
			end
			batch.push_back(rep);
		end else if (it.op == OP_TICK) begin
			ticks_seen++;
			// A repeated timestamp is dropped without any report.
			if (it.stamp != tbl_last_stamp) begin
				tbl_last_stamp = it.stamp;
				for (int i = 0; i < WIN_COUNT; i++) begin
					if (tbl_on[i] && !tbl_evt[i]) begin
						gap = it.stamp[15:0] - tbl_fired_at[i][15:0];
						if (gap >= tbl_per[i]) begin
							tbl_fired_at[i] = it.stamp;
							rep = '0;
							rep.kind = KIND_FIRED;
							rep.win = i[WIN_W-1:0];
							rep.cmd = tbl_cmd[i];
							rep.tag = tbl_tag[i];
							rep.dim = tbl_dim[i];
							batch.push_back(rep);
						end
					end
				end
			end
		end
		evw = 0;
		for (int i = 0; i < WIN_COUNT; i++)
			if (tbl_on[i] && tbl_evt[i])
				evw++;
		foreach (batch[k]) begin
			batch[k].evw = evw[EVW-1:0];
			batch[k].last = (k == batch.size() - 1);
			due_reports.push_back(batch[k]);
		end
	endtask

	task automatic add_compact(input logic [2:0] w, input logic [3:0] cmd, input logic evt,
			input logic [3:0] dimf, input logic [11:0] per);
		frame_item_t it;
		it.op = OP_COMPACT;
		it.b0 = {w, evt, cmd};
		it.b1 = {dimf, per[11:8]};
		it.b2 = per[7:0];
		it.b3 = 8'($urandom);
		it.b4 = 8'($urandom);
		it.stamp = $urandom;
		pending.push_back(it);
	endtask

	task automatic add_extended(input logic [2:0] w, input logic [3:0] cmd, input logic evt,
			input logic [7:0] dim, input logic [7:0] tag, input logic [15:0] per);
		frame_item_t it;
		it.op = OP_EXTENDED;
		it.b0 = {w, evt, cmd};
		it.b1 = dim;
		it.b2 = tag;
		it.b3 = per[15:8];
		it.b4 = per[7:0];
		it.stamp = $urandom;
		pending.push_back(it);
	endtask

	// Ticks and the unused code carry random bytes in the fields they ignore.
	task automatic add_other(input logic [1:0] code, input logic [31:0] stamp);
		frame_item_t it;
		it.op = code;
		it.b0 = 8'($urandom);
		it.b1 = 8'($urandom);
		it.b2 = 8'($urandom);
		it.b3 = 8'($urandom);
		it.b4 = 8'($urandom);
		it.stamp = stamp;
		pending.push_back(it);
	endtask

	// Sender: offers queued items, holds a stalled item, idles at random and has a stretch with no idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			accepted_items <= 0;
			loads_seen = 0;
			ticks_seen = 0;
			for (int i = 0; i < WIN_COUNT; i++) begin
				tbl_on[i] = 1'b0;
				tbl_evt[i] = 1'b0;
				tbl_cmd[i] = '0;
				tbl_tag[i] = '0;
				tbl_dim[i] = '0;
				tbl_per[i] = '0;
				tbl_fired_at[i] = '0;
			end
			tbl_last_stamp = '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_window_reports(cur_item);
				accepted_items <= accepted_items + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending.size() != 0 && ((accepted_items >= 200 && accepted_items < 300)
						|| $urandom_range(0, 99) >= 17)) begin
					cur_item = pending.pop_front();
					in_valid <= 1'b1;
					op <= cur_item.op;
					entry_b0 <= cur_item.b0;
					entry_b1 <= cur_item.b1;
					entry_b2 <= cur_item.b2;
					entry_b3 <= cur_item.b3;
					entry_b4 <= cur_item.b4;
					now_stamp <= cur_item.stamp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, one long hold-off, and a stretch with none.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && reports_seen >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !(reports_seen >= 150 && reports_seen < 250)
				&& ($urandom_range(0, 99) < 17);
		end
	end

	// Monitor: checks every accepted report against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reports_seen <= 0;
		end else if (out_valid && !out_stall) begin
			reports_seen <= reports_seen + 1;
			got = {kind, window, command, tag_kind, dim_level, event_windows, run_last};
			if (got.kind == KIND_FIRED)
				fires_seen++;
			if (due_reports.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("Unexpected report: kind %0d window %0d command %0d",
						got.kind, got.win, got.cmd);
			end else begin
				want = due_reports.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("Report %0d expected: kind %0d win %0d cmd %0d tag %0d dim %0d evw %0d last %0d",
							reports_seen, want.kind, want.win, want.cmd, want.tag,
							$signed(want.dim), want.evw, want.last);
						$display("Report %0d actual:   kind %0d win %0d cmd %0d tag %0d dim %0d evw %0d last %0d",
							reports_seen, got.kind, got.win, got.cmd, got.tag,
							$signed(got.dim), got.evw, got.last);
					end
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves an item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stuck_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin : run_control
		logic [31:0] gen_stamp;
		int          r;
		bit          timed_out;

		fail_count = 0;
		fires_seen = 0;

		// Directed part: repeated stamp at reset, field extremes, event mode,
		// zero period, wrap of the elapsed time and a tick that fires all windows.
		add_other(OP_TICK, 32'h0000_0000);
		add_compact(3'd0, 4'hF, 1'b0, 4'hF, 12'hFFF);
		add_compact(3'd1, 4'h1, 1'b0, 4'h0, 12'h000);
		add_extended(3'd2, 4'h5, 1'b0, 8'h80, 8'hFF, 16'hFFFF);
		add_extended(3'd3, 4'hA, 1'b0, 8'h7F, 8'h00, 16'd100);
		add_extended(3'd4, 4'h3, 1'b1, 8'h55, 8'hAA, 16'h0000);
		add_compact(3'd5, 4'h0, 1'b1, 4'h9, 12'h000);
		add_compact(3'd7, 4'h7, 1'b1, 4'h5, 12'd10);
		add_other(OP_TICK, 32'd50);
		add_other(OP_TICK, 32'd50);
		add_other(OP_TICK, 32'd150);
		add_other(OP_UNUSED, $urandom);
		add_other(OP_TICK, 32'd151);
		// Same low half as the previous stamp, so only the upper bits make it new.
		add_other(OP_TICK, 32'h0001_0097);
		add_other(OP_TICK, 32'hFFFF_FFFF);
		add_other(OP_TICK, 32'h0000_0010);
		for (int i = 0; i < WIN_COUNT; i++) begin
			if (i % 2 == 0)
				add_compact(i[2:0], 4'(i + 1), 1'b0, 4'(i), 12'h000);
			else
				add_extended(i[2:0], 4'hF - 4'(i), 1'b0, 8'($urandom), 8'($urandom), 16'h0000);
		end
		add_other(OP_TICK, 32'h0000_0020);
		gen_stamp = 32'h0000_0020;

		// Random part: mostly small periods and short steps so windows keep firing.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				add_compact(3'($urandom), 4'($urandom), ($urandom_range(0, 3) == 0), 4'($urandom),
					($urandom_range(0, 9) < 7) ? {4'h0, 8'($urandom)} : 12'($urandom));
			end else if (r < 40) begin
				add_extended(3'($urandom), 4'($urandom), ($urandom_range(0, 3) == 0),
					8'($urandom), 8'($urandom),
					($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 255)) : 16'($urandom));
			end else if (r < 88) begin
				r = $urandom_range(0, 9);
				if (r < 8)
					gen_stamp = gen_stamp + $urandom_range(1, 120);
				else if (r < 9)
					gen_stamp = gen_stamp + $urandom_range(1, 65535);
				else
					gen_stamp = $urandom;
				add_other(OP_TICK, gen_stamp);
			end else if (r < 94) begin
				add_other(OP_TICK, gen_stamp);
			end else begin
				add_other(OP_UNUSED, $urandom);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while ((pending.size() != 0 || in_valid || due_reports.size() != 0)
				&& stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		timed_out = (stuck_cycles >= STUCK_LIMIT);
		if (timed_out)
			$display("Watchdog expired after %0d cycles without progress.", stuck_cycles);
		else
			repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_reports.size() != 0) begin
			$display("%0d predicted reports never arrived.", due_reports.size());
			fail_count += due_reports.size();
		end

		$display("Covered %0d items (%0d loads, %0d ticks) with random stalls and one long hold-off.",
			accepted_items, loads_seen, ticks_seen);
		$display("Checked %0d reports, %0d of them window fires; %0d failures.",
			reports_seen, fires_seen, fail_count);
		if (!timed_out && fail_count == 0) begin
			$display("tb_windowed_periodic_frame_scheduler: PASS");
		end else begin
			$display("tb_windowed_periodic_frame_scheduler: FAIL");
		end
		$finish;
	end

endmodule

/* windowed_periodic_frame_scheduler.f */
+incdir+sv
sv/wpfs_pkg.sv
sv/wpfs_front.sv
sv/wpfs_fifo.sv
sv/wpfs_back.sv
sv/windowed_periodic_frame_scheduler.sv
bench/tb_windowed_periodic_frame_scheduler.sv
